### sv/cpsc_pkg.sv
// ----------------------------------------------------------------------------
// cpsc_pkg
// Shared types, command codes, state encodings and helpers for the
// convex polygon separating-axis collision block.
// ----------------------------------------------------------------------------
package cpsc_pkg;

    localparam int MAX_VERTS_DEF = 16;
    localparam int CW            = 32;
    localparam int NRM_W         = 18;
    localparam int FRAC          = 16;

    typedef enum logic [2:0] {
        CMD_CLEAR = 3'd0,
        CMD_ADD_A = 3'd1,
        CMD_ADD_B = 3'd2,
        CMD_OFF_A = 3'd3,
        CMD_OFF_B = 3'd4,
        CMD_EVAL  = 3'd5
    } cmd_t;

    typedef enum logic [4:0] {
        EV_IDLE,
        EV_SUM,
        EV_EDGE_I,
        EV_EDGE_J,
        EV_EDGE_D,
        EV_EDGE_CHK,
        EV_AXIS,
        EV_PROJ,
        EV_CMP,
        EV_BEST,
        EV_NEXT,
        EV_CEN1,
        EV_CEN2,
        EV_CEN3,
        EV_CEN4,
        EV_PUSH1,
        EV_PUSH2,
        EV_DONE
    } ev_state_t;

    typedef enum logic [2:0] {
        AX_IDLE,
        AX_NORM,
        AX_SQ,
        AX_SUM,
        AX_ROOT,
        AX_DINIT,
        AX_DIV,
        AX_FIN
    } ax_state_t;

    typedef struct packed {
        logic                    done;
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
    } axis_res_t;

    // Saturate a 36-bit signed value to signed 32 bits.
    function automatic logic signed [CW-1:0] sat32(input logic signed [35:0] v);
        logic signed [CW-1:0] r;
        begin
            if (v > 36'sd2147483647)
            begin
                r = 32'sh7FFF_FFFF;
            end
            else if (v < -36'sd2147483648)
            begin
                r = 32'sh8000_0000;
            end
            else
            begin
                r = v[CW-1:0];
            end
            return r;
        end
    endfunction

endpackage

### sv/convex_polygon_sat_collision.sv
// ----------------------------------------------------------------------------
// convex_polygon_sat_collision
// Separating-axis collision test between two convex polygons in fixed point.
// ----------------------------------------------------------------------------
// Clear, vertex and offset items are accepted back to back.
// An evaluate item holds stall high while it runs. One walk over max(count A,
// count B) addresses sums the moved vertices; then each nondegenerate edge costs one
// axis computation (up to 29 normalize shifts, 31 root steps, 18 divide steps)
// and one walk through the vertex memories. The result is valid as stall drops.
// Reset clears counts and offsets at once; the vertex memories are not cleared.
module convex_polygon_sat_collision import cpsc_pkg::*; #(
    parameter int MAX_VERTS = MAX_VERTS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_stall,
    input  logic [2:0]              command,
    input  logic signed [CW-1:0]    coord_x,
    input  logic signed [CW-1:0]    coord_y,
    output logic                    res_valid,
    input  logic                    res_stall,
    output logic                    hit,
    output logic signed [NRM_W-1:0] normal_x,
    output logic signed [NRM_W-1:0] normal_y,
    output logic [30:0]             depth,
    output logic signed [CW-1:0]    new_offset_bx,
    output logic signed [CW-1:0]    new_offset_by
);

    // Memory geometry and the widths of the datapath. Sums of moved vertices
    // grow with the vertex count; projections are exact Q19.32 dot products.
    localparam int ADDR_W = $clog2(MAX_VERTS);
    localparam int CNT_W  = $clog2(MAX_VERTS + 1);
    localparam int VW     = 2 * CW;
    localparam int SUM_W  = CW + CNT_W;
    localparam int PROD_W = CW + NRM_W;
    localparam int DOT_W  = PROD_W + 1;
    localparam int DIFF_W = DOT_W + 1;
    localparam int CP_W   = SUM_W + CNT_W + 1;
    localparam int CEN_W  = CP_W + 1;
    localparam int QW     = CEN_W + NRM_W;
    localparam int PP_W   = NRM_W + CW;
    localparam int RND_W  = PP_W + 1;
    localparam int PX_W   = RND_W - FRAC;
    localparam int DEP_W  = 31;

    ev_state_t state_reg, state_next;

    // Polygon bookkeeping; the vertices themselves live in the two memories.
    logic [CNT_W-1:0]     cnt_a_reg, cnt_b_reg;
    logic signed [CW-1:0] off_ax_reg, off_ay_reg, off_bx_reg, off_by_reg;

    // Memory ports.
    logic              wr_a, wr_b;
    logic [ADDR_W-1:0] rd_addr;
    logic [VW-1:0]     rd_a_data, rd_b_data;

    // Vertex walk pipeline: read issue, moved vertex, products, accumulate.
    logic [CNT_W-1:0]     walk_k_reg, walk_max_reg;
    logic                 walk_issue, walk_done;
    logic                 rd_vld_reg, rd_ina_reg, rd_inb_reg;
    logic                 mv_vld_reg, mv_ina_reg, mv_inb_reg;
    logic                 pr_vld_reg, pr_ina_reg, pr_inb_reg;
    logic signed [CW-1:0] mva_x, mva_y, mvb_x, mvb_y;
    logic signed [CW-1:0] mva_x_reg, mva_y_reg, mvb_x_reg, mvb_y_reg;
    logic signed [PROD_W-1:0] pax_reg, pay_reg, pbx_reg, pby_reg;
    logic signed [DOT_W-1:0]  dota, dotb;
    logic signed [DOT_W-1:0]  mna_reg, mxa_reg, mnb_reg, mxb_reg;
    logic                     a_first_reg, b_first_reg;
    logic signed [SUM_W-1:0]  sax_reg, say_reg, sbx_reg, sby_reg;

    // Edge walk.
    logic                 side_reg;
    logic [CNT_W-1:0]     ei_reg, ej, n_cur;
    logic                 last_edge;
    logic signed [CW-1:0] e0x_reg, e0y_reg, e1x_reg, e1y_reg;
    logic signed [CW-1:0] sv_x, sv_y;
    logic signed [32:0]   edge_dx, edge_dy;
    logic                 edge_zero;
    axis_res_t            axis_res;

    // Axis under test and the best axis so far.
    logic signed [NRM_W-1:0]  nx_reg, ny_reg, bnx_reg, bny_reg;
    logic signed [DIFF_W-1:0] d1_reg, d2_reg, best_reg, dmin;
    logic                     separated, have_reg, hit_reg;

    // Centroid direction test and push-out.
    logic signed [CP_W-1:0] cbx_reg, cax_reg, cby_reg, cay_reg;
    logic signed [CEN_W-1:0] cx_reg, cy_reg;
    logic signed [QW-1:0]    qx_reg, qy_reg;
    logic signed [QW:0]      qsum;
    logic [DEP_W-1:0]        depth_reg;
    logic signed [PP_W-1:0]  ppx_reg, ppy_reg;
    logic signed [RND_W-1:0] rndx, rndy;
    logic signed [PX_W-1:0]  pushx, pushy;

    // Result register: an item can wait here while loads keep flowing in.
    logic                    res_valid_reg, res_hit_reg, res_load;
    logic signed [NRM_W-1:0] res_nx_reg, res_ny_reg;
    logic [DEP_W-1:0]        res_depth_reg;
    logic signed [CW-1:0]    res_offx_reg, res_offy_reg;

    logic cmd_acc, eval_start, eval_empty;

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    assign cmd_stall  = (state_reg != EV_IDLE);
    assign cmd_acc    = cmd_valid && !cmd_stall;
    assign eval_start = cmd_acc && (command == CMD_EVAL);
    assign eval_empty = (cnt_a_reg == '0) || (cnt_b_reg == '0);

    assign wr_a = cmd_acc && (command == CMD_ADD_A) && (cnt_a_reg < CNT_W'(MAX_VERTS));
    assign wr_b = cmd_acc && (command == CMD_ADD_B) && (cnt_b_reg < CNT_W'(MAX_VERTS));

    cpsc_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTS)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (wr_a),
        .wr_addr (cnt_a_reg[ADDR_W-1:0]),
        .wr_data ({coord_y, coord_x}),
        .rd_addr (rd_addr),
        .rd_data (rd_a_data)
    );

    cpsc_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTS)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (wr_b),
        .wr_addr (cnt_b_reg[ADDR_W-1:0]),
        .wr_data ({coord_y, coord_x}),
        .rd_addr (rd_addr),
        .rd_data (rd_b_data)
    );

    // ------------------------------------------------------------------------
    // Read addressing and moved vertices
    // ------------------------------------------------------------------------
    always_comb
    begin
        n_cur     = side_reg ? cnt_b_reg : cnt_a_reg;
        last_edge = (ei_reg + CNT_W'(1)) == n_cur;
        ej        = last_edge ? '0 : ei_reg + CNT_W'(1);

        priority case (state_reg)
            EV_EDGE_I: rd_addr = ei_reg[ADDR_W-1:0];
            EV_EDGE_J: rd_addr = ej[ADDR_W-1:0];
            default:   rd_addr = walk_k_reg[ADDR_W-1:0];
        endcase

        // A vertex is moved by its polygon's offset and saturated to Q16.16.
        mva_x = sat32(36'(signed'(rd_a_data[CW-1:0]))  + 36'(off_ax_reg));
        mva_y = sat32(36'(signed'(rd_a_data[VW-1:CW])) + 36'(off_ay_reg));
        mvb_x = sat32(36'(signed'(rd_b_data[CW-1:0]))  + 36'(off_bx_reg));
        mvb_y = sat32(36'(signed'(rd_b_data[VW-1:CW])) + 36'(off_by_reg));
        sv_x  = side_reg ? mvb_x : mva_x;
        sv_y  = side_reg ? mvb_y : mva_y;

        edge_dx   = 33'(e1x_reg) - 33'(e0x_reg);
        edge_dy   = 33'(e1y_reg) - 33'(e0y_reg);
        edge_zero = (edge_dx == '0) && (edge_dy == '0);

        walk_issue = ((state_reg == EV_SUM) || (state_reg == EV_PROJ))
                     && (walk_k_reg < walk_max_reg);
        walk_done  = (walk_k_reg == walk_max_reg)
                     && !rd_vld_reg && !mv_vld_reg && !pr_vld_reg;

        dota = DOT_W'(pax_reg) + DOT_W'(pay_reg);
        dotb = DOT_W'(pbx_reg) + DOT_W'(pby_reg);

        // Touching projections count as separation.
        separated = (mna_reg >= mxb_reg) || (mnb_reg >= mxa_reg);
        dmin      = (d1_reg < d2_reg) ? d1_reg : d2_reg;

        qsum = (QW+1)'(qx_reg) + (QW+1)'(qy_reg);

        // Push-out is rounded half up, then floored back to Q16.16.
        rndx  = RND_W'(ppx_reg) + RND_W'(32768);
        rndy  = RND_W'(ppy_reg) + RND_W'(32768);
        pushx = rndx[RND_W-1:FRAC];
        pushy = rndy[RND_W-1:FRAC];

        res_load = (state_reg == EV_DONE) && (!res_valid_reg || !res_stall);
    end

    cpsc_axis u_axis (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == EV_EDGE_CHK && !edge_zero),
        .dx    (edge_dx),
        .dy    (edge_dy),
        .res   (axis_res)
    );

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            EV_IDLE:     if (eval_start) state_next = eval_empty ? EV_DONE : EV_SUM;
            EV_SUM:      if (walk_done) state_next = EV_EDGE_I;
            EV_EDGE_I:   state_next = EV_EDGE_J;
            EV_EDGE_J:   state_next = EV_EDGE_D;
            EV_EDGE_D:   state_next = EV_EDGE_CHK;
            EV_EDGE_CHK: state_next = edge_zero ? EV_NEXT : EV_AXIS;
            EV_AXIS:     if (axis_res.done) state_next = EV_PROJ;
            EV_PROJ:     if (walk_done) state_next = EV_CMP;
            EV_CMP:      state_next = separated ? EV_DONE : EV_BEST;
            EV_BEST:     state_next = EV_NEXT;
            EV_NEXT:
            begin
                if (!last_edge || !side_reg)
                begin
                    state_next = EV_EDGE_I;
                end
                else
                begin
                    state_next = have_reg ? EV_CEN1 : EV_DONE;
                end
            end
            EV_CEN1:     state_next = EV_CEN2;
            EV_CEN2:     state_next = EV_CEN3;
            EV_CEN3:     state_next = EV_CEN4;
            EV_CEN4:     state_next = EV_PUSH1;
            EV_PUSH1:    state_next = EV_PUSH2;
            EV_PUSH2:    state_next = EV_DONE;
            EV_DONE:     if (res_load) state_next = EV_IDLE;
        endcase
    end

    // Control state: counts, offsets, walk valids, edge position, result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EV_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            off_ax_reg    <= '0;
            off_ay_reg    <= '0;
            off_bx_reg    <= '0;
            off_by_reg    <= '0;
            walk_k_reg    <= '0;
            walk_max_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            mv_vld_reg    <= 1'b0;
            pr_vld_reg    <= 1'b0;
            side_reg      <= 1'b0;
            ei_reg        <= '0;
            have_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cmd_acc)
            begin
                unique case (command)
                    CMD_CLEAR:
                    begin
                        cnt_a_reg  <= '0;
                        cnt_b_reg  <= '0;
                        off_ax_reg <= '0;
                        off_ay_reg <= '0;
                        off_bx_reg <= '0;
                        off_by_reg <= '0;
                    end
                    CMD_ADD_A: if (wr_a) cnt_a_reg <= cnt_a_reg + CNT_W'(1);
                    CMD_ADD_B: if (wr_b) cnt_b_reg <= cnt_b_reg + CNT_W'(1);
                    CMD_OFF_A:
                    begin
                        off_ax_reg <= coord_x;
                        off_ay_reg <= coord_y;
                    end
                    CMD_OFF_B:
                    begin
                        off_bx_reg <= coord_x;
                        off_by_reg <= coord_y;
                    end
                    CMD_EVAL:
                    begin
                        hit_reg      <= 1'b0;
                        have_reg     <= 1'b0;
                        side_reg     <= 1'b0;
                        ei_reg       <= '0;
                        walk_k_reg   <= '0;
                        walk_max_reg <= (cnt_a_reg > cnt_b_reg) ? cnt_a_reg : cnt_b_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Walk issue and pipeline valids.
            if (walk_issue)
            begin
                walk_k_reg <= walk_k_reg + CNT_W'(1);
            end
            else if (state_reg == EV_AXIS && axis_res.done)
            begin
                walk_k_reg <= '0;
            end
            rd_vld_reg <= walk_issue;
            mv_vld_reg <= rd_vld_reg;
            pr_vld_reg <= mv_vld_reg && (state_reg == EV_PROJ);

            if (state_reg == EV_NEXT)
            begin
                if (!last_edge)
                begin
                    ei_reg <= ei_reg + CNT_W'(1);
                end
                else
                begin
                    ei_reg   <= '0;
                    side_reg <= 1'b1;
                end
            end

            if (state_reg == EV_BEST && (!have_reg || dmin < best_reg))
            begin
                have_reg <= 1'b1;
            end

            if (state_reg == EV_PUSH2)
            begin
                hit_reg    <= 1'b1;
                off_bx_reg <= sat32(36'(off_bx_reg) + 36'(pushx));
                off_by_reg <= sat32(36'(off_by_reg) + 36'(pushy));
            end

            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rd_ina_reg <= walk_k_reg < cnt_a_reg;
        rd_inb_reg <= walk_k_reg < cnt_b_reg;
        mv_ina_reg <= rd_ina_reg;
        mv_inb_reg <= rd_inb_reg;
        pr_ina_reg <= mv_ina_reg;
        pr_inb_reg <= mv_inb_reg;
        mva_x_reg  <= mva_x;
        mva_y_reg  <= mva_y;
        mvb_x_reg  <= mvb_x;
        mvb_y_reg  <= mvb_y;
        pax_reg    <= mva_x_reg * nx_reg;
        pay_reg    <= mva_y_reg * ny_reg;
        pbx_reg    <= mvb_x_reg * nx_reg;
        pby_reg    <= mvb_y_reg * ny_reg;

        if (eval_start)
        begin
            sax_reg <= '0;
            say_reg <= '0;
            sbx_reg <= '0;
            sby_reg <= '0;
        end
        else if (state_reg == EV_SUM && mv_vld_reg)
        begin
            if (mv_ina_reg)
            begin
                sax_reg <= sax_reg + SUM_W'(mva_x_reg);
                say_reg <= say_reg + SUM_W'(mva_y_reg);
            end
            if (mv_inb_reg)
            begin
                sbx_reg <= sbx_reg + SUM_W'(mvb_x_reg);
                sby_reg <= sby_reg + SUM_W'(mvb_y_reg);
            end
        end

        if (state_reg == EV_EDGE_J)
        begin
            e0x_reg <= sv_x;
            e0y_reg <= sv_y;
        end
        if (state_reg == EV_EDGE_D)
        begin
            e1x_reg <= sv_x;
            e1y_reg <= sv_y;
        end

        if (state_reg == EV_AXIS && axis_res.done)
        begin
            nx_reg      <= axis_res.nx;
            ny_reg      <= axis_res.ny;
            a_first_reg <= 1'b1;
            b_first_reg <= 1'b1;
        end
        else if (pr_vld_reg)
        begin
            if (pr_ina_reg)
            begin
                if (a_first_reg || dota < mna_reg) mna_reg <= dota;
                if (a_first_reg || dota > mxa_reg) mxa_reg <= dota;
                a_first_reg <= 1'b0;
            end
            if (pr_inb_reg)
            begin
                if (b_first_reg || dotb < mnb_reg) mnb_reg <= dotb;
                if (b_first_reg || dotb > mxb_reg) mxb_reg <= dotb;
                b_first_reg <= 1'b0;
            end
        end

        if (state_reg == EV_CMP)
        begin
            d1_reg <= DIFF_W'(mxb_reg) - DIFF_W'(mna_reg);
            d2_reg <= DIFF_W'(mxa_reg) - DIFF_W'(mnb_reg);
        end

        // The first axis wins ties.
        if (state_reg == EV_BEST && (!have_reg || dmin < best_reg))
        begin
            best_reg <= dmin;
            bnx_reg  <= nx_reg;
            bny_reg  <= ny_reg;
        end

        if (state_reg == EV_CEN1)
        begin
            cbx_reg <= sbx_reg * signed'({1'b0, cnt_a_reg});
            cax_reg <= sax_reg * signed'({1'b0, cnt_b_reg});
            cby_reg <= sby_reg * signed'({1'b0, cnt_a_reg});
            cay_reg <= say_reg * signed'({1'b0, cnt_b_reg});
        end
        if (state_reg == EV_CEN2)
        begin
            cx_reg <= CEN_W'(cbx_reg) - CEN_W'(cax_reg);
            cy_reg <= CEN_W'(cby_reg) - CEN_W'(cay_reg);
        end
        if (state_reg == EV_CEN3)
        begin
            qx_reg <= cx_reg * bnx_reg;
            qy_reg <= cy_reg * bny_reg;
        end
        if (state_reg == EV_CEN4)
        begin
            // Point the axis from the centroid of A toward the centroid of B.
            if (qsum[QW])
            begin
                bnx_reg <= -bnx_reg;
                bny_reg <= -bny_reg;
            end
            if (best_reg[DIFF_W-1:FRAC+DEP_W] != '0)
            begin
                depth_reg <= '1;
            end
            else
            begin
                depth_reg <= best_reg[FRAC+DEP_W-1:FRAC];
            end
        end
        if (state_reg == EV_PUSH1)
        begin
            ppx_reg <= bnx_reg * signed'({1'b0, depth_reg});
            ppy_reg <= bny_reg * signed'({1'b0, depth_reg});
        end

        if (res_load)
        begin
            res_hit_reg   <= hit_reg;
            res_nx_reg    <= hit_reg ? bnx_reg : '0;
            res_ny_reg    <= hit_reg ? bny_reg : '0;
            res_depth_reg <= hit_reg ? depth_reg : '0;
            res_offx_reg  <= off_bx_reg;
            res_offy_reg  <= off_by_reg;
        end
    end

    assign res_valid     = res_valid_reg;
    assign hit           = res_hit_reg;
    assign normal_x      = res_nx_reg;
    assign normal_y      = res_ny_reg;
    assign depth         = res_depth_reg;
    assign new_offset_bx = res_offx_reg;
    assign new_offset_by = res_offy_reg;

endmodule

### sv/cpsc_ram.sv
// ----------------------------------------------------------------------------
// cpsc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module cpsc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/cpsc_axis.sv
// ----------------------------------------------------------------------------
// cpsc_axis
// Turns an edge vector into a unit normal in Q1.16: normalizes the
// magnitudes one shift per cycle, squares them, takes a bit-pair integer
// square root and divides both components by the length bit by bit.
// ----------------------------------------------------------------------------
module cpsc_axis import cpsc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [32:0] dx,
    input  logic signed [32:0] dy,
    output axis_res_t          res
);

    localparam int MAG_W  = 33;
    localparam int NORM_W = 30;
    localparam int SQ_W   = 2 * NORM_W;
    localparam int ROOT_W = 62;
    localparam int LEN_W  = 31;
    localparam int Q_W    = 18;
    localparam int NUM_W  = 48;
    localparam int STEP_W = 5;
    localparam int ROOT_STEPS = 30;
    localparam int DIV_STEPS  = Q_W - 1;

    ax_state_t state_reg, state_next;

    logic [MAG_W-1:0]  ax_reg, ay_reg;
    logic              flipx_reg, flipy_reg;
    logic [SQ_W-1:0]   sqx_reg, sqy_reg;
    logic [ROOT_W-1:0] v_reg, r_reg;
    logic [STEP_W-1:0] step_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [NUM_W-1:0]  remx_reg, remy_reg;
    logic [Q_W-1:0]    qx_reg, qy_reg;

    logic [MAG_W-1:0]  mag_x, mag_y, mag_max;
    logic [ROOT_W-1:0] root_bit, root_trial, v_next, r_next;
    logic [NUM_W-1:0]  dsub;
    logic              qbx, qby;

    always_comb
    begin
        mag_x   = dx[32] ? MAG_W'(-dx) : MAG_W'(dx);
        mag_y   = dy[32] ? MAG_W'(-dy) : MAG_W'(dy);
        mag_max = (ax_reg > ay_reg) ? ax_reg : ay_reg;

        root_bit   = ROOT_W'(1) << {step_reg, 1'b0};
        root_trial = r_reg + root_bit;
        if (v_reg >= root_trial)
        begin
            v_next = v_reg - root_trial;
            r_next = (r_reg >> 1) + root_bit;
        end
        else
        begin
            v_next = v_reg;
            r_next = r_reg >> 1;
        end

        dsub = NUM_W'(len_reg) << step_reg;
        qbx  = (remx_reg >= dsub);
        qby  = (remy_reg >= dsub);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            AX_IDLE:  if (start) state_next = AX_NORM;
            AX_NORM:  if (mag_max[MAG_W-1:NORM_W] == '0 && mag_max[NORM_W-1])
                          state_next = AX_SQ;
            AX_SQ:    state_next = AX_SUM;
            AX_SUM:   state_next = AX_ROOT;
            AX_ROOT:  if (step_reg == '0) state_next = AX_DINIT;
            AX_DINIT: state_next = AX_DIV;
            AX_DIV:   if (step_reg == '0) state_next = AX_FIN;
            AX_FIN:   state_next = AX_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AX_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            AX_IDLE:
            begin
                ax_reg    <= mag_x;
                ay_reg    <= mag_y;
                flipx_reg <= (dy > 33'sd0);
                flipy_reg <= dx[32];
            end
            AX_NORM:
            begin
                if (mag_max[MAG_W-1:NORM_W] != '0)
                begin
                    ax_reg <= ax_reg >> 1;
                    ay_reg <= ay_reg >> 1;
                end
                else if (!mag_max[NORM_W-1])
                begin
                    ax_reg <= ax_reg << 1;
                    ay_reg <= ay_reg << 1;
                end
            end
            AX_SQ:
            begin
                sqx_reg <= ax_reg[NORM_W-1:0] * ax_reg[NORM_W-1:0];
                sqy_reg <= ay_reg[NORM_W-1:0] * ay_reg[NORM_W-1:0];
            end
            AX_SUM:
            begin
                v_reg    <= ROOT_W'(sqx_reg) + ROOT_W'(sqy_reg);
                r_reg    <= '0;
                step_reg <= STEP_W'(ROOT_STEPS);
            end
            AX_ROOT:
            begin
                v_reg    <= v_next;
                r_reg    <= r_next;
                step_reg <= step_reg - STEP_W'(1);
                len_reg  <= r_next[LEN_W-1:0];
            end
            AX_DINIT:
            begin
                remx_reg <= NUM_W'({ay_reg[NORM_W-1:0], {FRAC{1'b0}}}) + NUM_W'(len_reg >> 1);
                remy_reg <= NUM_W'({ax_reg[NORM_W-1:0], {FRAC{1'b0}}}) + NUM_W'(len_reg >> 1);
                qx_reg   <= '0;
                qy_reg   <= '0;
                step_reg <= STEP_W'(DIV_STEPS);
            end
            AX_DIV:
            begin
                if (qbx) remx_reg <= remx_reg - dsub;
                if (qby) remy_reg <= remy_reg - dsub;
                qx_reg   <= {qx_reg[Q_W-2:0], qbx};
                qy_reg   <= {qy_reg[Q_W-2:0], qby};
                step_reg <= step_reg - STEP_W'(1);
            end
            AX_FIN:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.done = (state_reg == AX_FIN);
        res.nx   = flipx_reg ? -$signed(qx_reg) : $signed(qx_reg);
        res.ny   = flipy_reg ? -$signed(qy_reg) : $signed(qy_reg);
    end

endmodule

### sv/cpsc_checker.sv
// ----------------------------------------------------------------------------
// cpsc_checker
// Port-level assertions for the polygon collision block, bound to its top.
// ----------------------------------------------------------------------------
module cpsc_checker import cpsc_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    cmd_valid,
    input logic                    cmd_stall,
    input logic [2:0]              command,
    input logic                    res_valid,
    input logic                    res_stall,
    input logic                    hit,
    input logic signed [NRM_W-1:0] normal_x,
    input logic signed [NRM_W-1:0] normal_y,
    input logic [30:0]             depth,
    input logic signed [CW-1:0]    new_offset_bx,
    input logic signed [CW-1:0]    new_offset_by
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(hit) && $stable(depth)
            && $stable(new_offset_bx) && $stable(new_offset_by))
        else $error("result item changed while stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !hit |-> normal_x == '0 && normal_y == '0 && depth == '0)
        else $error("miss reported with a nonzero normal or depth");

    a_hit_normal: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && hit |-> (normal_x != '0 || normal_y != '0)
            && normal_x <= 18'sd65536 && normal_x >= -18'sd65536
            && normal_y <= 18'sd65536 && normal_y >= -18'sd65536)
        else $error("hit reported with an invalid normal");

    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && command == CMD_EVAL |=> cmd_stall)
        else $error("evaluate item did not hold off the next item");

endmodule

bind convex_polygon_sat_collision cpsc_checker u_cpsc_checker (.*);

### verif/tb_convex_polygon_sat_collision.sv
// ----------------------------------------------------------------------------
// tb_convex_polygon_sat_collision
// Self-checking testbench for the separating-axis polygon collision block.
// Items are driven through the command channel and checked against an
// in-bench fixed-point collision predictor. The command channel idles
// and the result channel stalls at random.
// ----------------------------------------------------------------------------
module tb_convex_polygon_sat_collision;
    import cpsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV = MAX_VERTS_DEF;
    localparam int CYCLE_LIMIT = 2000000;

    // Command codes that the block ignores.
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    // One expected evaluate result.
    typedef struct {
        logic                    hit;
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic [30:0]             depth;
        logic signed [CW-1:0]    obx;
        logic signed [CW-1:0]    oby;
    } contact_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    logic [2:0] command = '0;
    logic signed [CW-1:0] coord_x = '0;
    logic signed [CW-1:0] coord_y = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    logic hit;
    logic signed [NRM_W-1:0] normal_x, normal_y;
    logic [30:0] depth;
    logic signed [CW-1:0] new_offset_bx, new_offset_by;

    convex_polygon_sat_collision dut (.*);

    always #1 clk = ~clk;

    // Shadow copy of the block state for the predictor.
    longint shape_a [NV][2];
    longint shape_b [NV][2];
    int     count_a, count_b;
    longint ofs_a [2];
    longint ofs_b [2];
    longint moved_a [NV][2];
    longint moved_b [NV][2];

    contact_t pending_contacts[$];
    int errors = 0;
    longint cycles = 0;
    int scene_count = 0;

    // Long gaps should be rare: mostly short gaps with occasional long ones.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // Unit normal (-dy, dx) in Q1.16 from a normalized edge vector.
    task automatic edge_normal(input longint dx, input longint dy,
                               output longint nx, output longint ny);
        longint unsigned ax, ay, m, len, mx, my;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        m = ax > ay ? ax : ay;
        while (m >= (64'd1 << 30))
        begin
            ax >>= 1; ay >>= 1; m >>= 1;
        end
        while (m < (64'd1 << 29))
        begin
            ax <<= 1; ay <<= 1; m <<= 1;
        end
        len = int_sqrt(ax * ax + ay * ay);
        mx = (ay * 65536 + len / 2) / len;
        my = (ax * 65536 + len / 2) / len;
        nx = dy > 0 ? -longint'(mx) : longint'(mx);
        ny = dx < 0 ? -longint'(my) : longint'(my);
    endtask

    task automatic extent(input bit side_b, input longint nx, input longint ny,
                          output longint lo, output longint hi);
        int n;
        longint p;
        n = side_b ? count_b : count_a;
        for (int i = 0; i < n; i++)
        begin
            p = side_b ? moved_b[i][0] * nx + moved_b[i][1] * ny
                       : moved_a[i][0] * nx + moved_a[i][1] * ny;
            if (i == 0 || p < lo) lo = p;
            if (i == 0 || p > hi) hi = p;
        end
    endtask

    // Separating-axis test on the current shapes; returns 1 on overlap.
    task automatic find_contact(output bit overlap, output longint bnx,
                                output longint bny, output longint bdepth);
        longint sax, say, sbx, sby, best, dx, dy, nx, ny;
        longint la, ha, lb, hb, d, cx, cy;
        bit have;
        int n, j;
        overlap = 0; bnx = 0; bny = 0; bdepth = 0;
        have = 0; best = 0;
        sax = 0; say = 0; sbx = 0; sby = 0;
        if (count_a == 0 || count_b == 0) return;
        for (int i = 0; i < count_a; i++)
        begin
            moved_a[i][0] = clamp32(shape_a[i][0] + ofs_a[0]);
            moved_a[i][1] = clamp32(shape_a[i][1] + ofs_a[1]);
            sax += moved_a[i][0]; say += moved_a[i][1];
        end
        for (int i = 0; i < count_b; i++)
        begin
            moved_b[i][0] = clamp32(shape_b[i][0] + ofs_b[0]);
            moved_b[i][1] = clamp32(shape_b[i][1] + ofs_b[1]);
            sbx += moved_b[i][0]; sby += moved_b[i][1];
        end
        for (int s = 0; s < 2; s++)
        begin
            n = s == 0 ? count_a : count_b;
            for (int i = 0; i < n; i++)
            begin
                j = (i + 1 == n) ? 0 : i + 1;
                if (s == 0)
                begin
                    dx = moved_a[j][0] - moved_a[i][0];
                    dy = moved_a[j][1] - moved_a[i][1];
                end
                else
                begin
                    dx = moved_b[j][0] - moved_b[i][0];
                    dy = moved_b[j][1] - moved_b[i][1];
                end
                if (dx == 0 && dy == 0) continue;
                edge_normal(dx, dy, nx, ny);
                extent(0, nx, ny, la, ha);
                extent(1, nx, ny, lb, hb);
                // Touching projections count as separated; a miss reports no axis.
                if (la >= hb || lb >= ha)
                begin
                    bnx = 0; bny = 0;
                    return;
                end
                d = (hb - la) < (ha - lb) ? (hb - la) : (ha - lb);
                if (!have || d < best)
                begin
                    have = 1; best = d; bnx = nx; bny = ny;
                end
            end
        end
        if (!have)
        begin
            bnx = 0; bny = 0;
            return;
        end
        cx = sbx * count_a - sax * count_b;
        cy = sby * count_a - say * count_b;
        if (cx * bnx + cy * bny < 0)
        begin
            bnx = -bnx; bny = -bny;
        end
        best = best / 65536;
        if (best > 64'sd2147483647) best = 64'sd2147483647;
        bdepth = best;
        overlap = 1;
    endtask

    function automatic longint round_q16(longint p);
        if (p >= 0) return p / 65536;
        return -((-p + 65535) / 65536);
    endfunction

    // Update the shadow state for one accepted item and queue any result.
    task automatic predict_item(input logic [2:0] op, input logic signed [31:0] x,
                                input logic signed [31:0] y);
        contact_t c;
        bit ov;
        longint nx, ny, dp;
        case (op)
            CMD_CLEAR:
            begin
                count_a = 0; count_b = 0;
                ofs_a = '{0, 0}; ofs_b = '{0, 0};
            end
            CMD_ADD_A:
                if (count_a < NV)
                begin
                    shape_a[count_a] = '{x, y};
                    count_a++;
                end
            CMD_ADD_B:
                if (count_b < NV)
                begin
                    shape_b[count_b] = '{x, y};
                    count_b++;
                end
            CMD_OFF_A: ofs_a = '{x, y};
            CMD_OFF_B: ofs_b = '{x, y};
            CMD_EVAL:
            begin
                find_contact(ov, nx, ny, dp);
                if (ov)
                begin
                    ofs_b[0] = clamp32(ofs_b[0] + round_q16(nx * dp + 32768));
                    ofs_b[1] = clamp32(ofs_b[1] + round_q16(ny * dp + 32768));
                end
                c.hit = ov;
                c.nx = NRM_W'(nx); c.ny = NRM_W'(ny); c.depth = 31'(dp);
                c.obx = CW'(ofs_b[0]); c.oby = CW'(ofs_b[1]);
                pending_contacts.push_back(c);
            end
            default: ;
        endcase
    endtask

    // Drive one item at the falling edge and hold it until accepted. Valid
    // stays high into the next item unless a gap comes first.
    task automatic send_item(input logic [2:0] op, input logic signed [31:0] x,
                             input logic signed [31:0] y);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        command <= op;
        coord_x <= x;
        coord_y <= y;
        do @(posedge clk); while (cmd_stall);
        predict_item(op, x, y);
        @(negedge clk);
    endtask

    // Result checker: compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        contact_t e;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_contacts.size() == 0)
            begin
                $display("%0t: unexpected result hit=%0d", $realtime, hit);
                errors++;
            end
            else
            begin
                e = pending_contacts.pop_front();
                if (hit !== e.hit || normal_x !== e.nx || normal_y !== e.ny ||
                    depth !== e.depth || new_offset_bx !== e.obx ||
                    new_offset_by !== e.oby)
                begin
                    $display("%0t: mismatch expected hit=%0d n=(%0d,%0d) d=%0d ob=(%0d,%0d)",
                             $realtime, e.hit, e.nx, e.ny, e.depth, e.obx, e.oby);
                    $display("%0t:          actual hit=%0d n=(%0d,%0d) d=%0d ob=(%0d,%0d)",
                             $realtime, hit, normal_x, normal_y, depth,
                             new_offset_bx, new_offset_by);
                    errors++;
                end
            end
        end
    end

    // Result-side stall: random gaps, with quiet stretches now and then.
    always @(negedge clk)
    begin
        if (!rst_n || (cycles / 3000) % 4 == 3)
            res_stall <= 1'b0;
        else
            res_stall <= ($urandom_range(0, 99) < 30) ||
                         ($urandom_range(0, 99) < 3 && res_stall);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_convex_polygon_sat_collision failed");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_coord(int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // Loads a random convex polygon: points on a rough circle, in order.
    task automatic load_shape(input logic [2:0] op, input int n, input int r,
                              input int cx, input int cy);
        real ang;
        for (int i = 0; i < n; i++)
        begin
            ang = 6.2831853 * (i + $urandom_range(0, 40) / 100.0) / n;
            send_item(op, cx + $rtoi(r * $cos(ang)), cy + $rtoi(r * $sin(ang)));
        end
    endtask

    task automatic test_directed();
        // Evaluate with empty polygons gives no hit.
        send_item(CMD_EVAL, 0, 0);
        // A square of side 2.0 and an overlapping triangle.
        send_item(CMD_ADD_A, 0, 0);
        send_item(CMD_ADD_A, 32'sh20000, 0);
        send_item(CMD_ADD_A, 32'sh20000, 32'sh20000);
        send_item(CMD_ADD_A, 0, 32'sh20000);
        send_item(CMD_ADD_B, 32'sh10000, 32'sh10000);
        send_item(CMD_ADD_B, 32'sh30000, 32'sh10000);
        send_item(CMD_ADD_B, 32'sh30000, 32'sh30000);
        send_item(CMD_EVAL, 0, 0);
        // Touching after push-out counts as separation.
        send_item(CMD_EVAL, 0, 0);
        send_item(CMD_OFF_A, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_item(CMD_OFF_B, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_item(CMD_EVAL, 0, 0);
        send_item(CMD_SPARE_LO, 1, 1);
        send_item(CMD_SPARE_HI, -1, -1);
        send_item(CMD_CLEAR, 0, 0);
        // All points equal: every edge is degenerate, no axis.
        send_item(CMD_ADD_A, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_item(CMD_ADD_A, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_item(CMD_ADD_B, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_item(CMD_EVAL, 0, 0);
        send_item(CMD_CLEAR, 0, 0);
        // Fill A past its capacity; extra vertices are dropped.
        load_shape(CMD_ADD_A, NV + 2, 32'h40000, 0, 0);
        load_shape(CMD_ADD_B, 3, 32'h40000, 32'h10000, 0);
        send_item(CMD_EVAL, 0, 0);
    endtask

    task automatic test_random_scenes();
        int na, nb, ra, rb;
        while (cycles < CYCLE_LIMIT / 2 && pending_contacts.size() < 100000)
        begin
            if (scene_count >= 150) break;
            scene_count++;
            send_item(CMD_CLEAR, 0, 0);
            na = $urandom_range(1, 6);
            nb = $urandom_range(1, 6);
            if ($urandom_range(0, 19) == 0) na = NV;
            ra = $urandom_range(1, 1 << 22);
            rb = $urandom_range(1, 1 << 22);
            load_shape(CMD_ADD_A, na, ra, rand_coord(1 << 20), rand_coord(1 << 20));
            load_shape(CMD_ADD_B, nb, rb, rand_coord(1 << 20), rand_coord(1 << 20));
            if ($urandom_range(0, 3) == 0)
                send_item(CMD_OFF_A, rand_coord(1 << 21), rand_coord(1 << 21));
            if ($urandom_range(0, 3) == 0)
                send_item(CMD_OFF_B, rand_coord(1 << 21), rand_coord(1 << 21));
            // Noise: unused codes and raw full-range items.
            if ($urandom_range(0, 7) == 0)
                send_item(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                          $urandom, $urandom);
            if ($urandom_range(0, 9) == 0)
                send_item(3'($urandom_range(CMD_ADD_A, CMD_OFF_B)), $urandom, $urandom);
            repeat ($urandom_range(1, 3)) send_item(CMD_EVAL, $urandom, $urandom);
        end
    endtask

    initial
    begin
        count_a = 0; count_b = 0;
        ofs_a = '{0, 0}; ofs_b = '{0, 0};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_scenes();
        cmd_valid <= 1'b0;
        while (pending_contacts.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("tb_convex_polygon_sat_collision passed");
        else
            $display("tb_convex_polygon_sat_collision failed");
        $finish;
    end

endmodule
